/* sv/ps2_mouse_cursor_tracker_macros.svh */
// Assertion macros shared by the cursor tracker RTL.
`ifndef PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PS2MCT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2mct: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2mct: next-cycle check failed");

`endif

/* sv/ps2mct_pkg.sv */
// Types, constants and helpers for the PS/2 cursor tracker.
`timescale 1ns / 1ps
package ps2mct_pkg;

  localparam int POSITION_BITS = 12;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int DELTA_W       = 10;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd768;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Header byte bit positions
  localparam int HDR_LEFT    = 0;
  localparam int HDR_RIGHT   = 1;
  localparam int HDR_MIDDLE  = 2;
  localparam int HDR_SYNC    = 3;
  localparam int HDR_X_SIGN  = 4;
  localparam int HDR_Y_SIGN  = 5;
  localparam int HDR_X_OVF   = 6;
  localparam int HDR_Y_OVF   = 7;

  localparam logic signed [DELTA_W-1:0] OVF_EXTRA = 10'sd255;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_X   = 2'd1,
    PH_Y   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

  // 9-bit two's complement delta, widened by the overflow extra.
  function automatic logic signed [DELTA_W-1:0] signed_delta(
    input logic [7:0] mag,
    input logic       neg,
    input logic       ovf
  );
    logic signed [DELTA_W-1:0] d;
    d = signed'({{(DELTA_W-8){neg}}, mag});
    if (ovf) begin
      d = neg ? (d - OVF_EXTRA) : (d + OVF_EXTRA);
    end
    return d;
  endfunction

endpackage

/* sv/ps2mct_assembler.sv */
// Byte-to-packet assembler: drops the first byte, syncs on header bit 3.
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_macros.svh"
module ps2mct_assembler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  output logic               byte_ready_o,
  input  logic [7:0]         byte_i,
  output logic               pkt_valid_o,
  input  logic               pkt_ready_i,
  output ps2mct_pkg::pkt_t   pkt_o
);

  ps2mct_pkg::phase_e phase_q, phase_d;
  logic               skip_q, skip_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [7:0]         xb_q, xb_d;
  logic               pkt_v_q, pkt_v_d;
  ps2mct_pkg::pkt_t   pkt_q, pkt_d;
  logic               byte_take;
  logic               pkt_load;

  assign byte_ready_o = !pkt_v_q || pkt_ready_i;
  assign byte_take    = byte_valid_i && byte_ready_o;

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    hdr_d    = hdr_q;
    xb_d     = xb_q;
    pkt_load = 1'b0;
    if (byte_take) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else begin
        unique case (phase_q)
          ps2mct_pkg::PH_X: begin
            xb_d    = byte_i;
            phase_d = ps2mct_pkg::PH_Y;
          end
          ps2mct_pkg::PH_Y: begin
            phase_d  = ps2mct_pkg::PH_HDR;
            pkt_load = 1'b1;
          end
          default: begin
            phase_d = ps2mct_pkg::PH_HDR;
            if (byte_i[ps2mct_pkg::HDR_SYNC]) begin
              hdr_d   = byte_i;
              phase_d = ps2mct_pkg::PH_X;
            end
          end
        endcase
      end
    end
    pkt_d = '{header: hdr_q, x_byte: xb_q, y_byte: byte_i};
    if (pkt_load) begin
      pkt_v_d = 1'b1;
    end else if (pkt_ready_i) begin
      pkt_v_d = 1'b0;
    end else begin
      pkt_v_d = pkt_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ps2mct_pkg::PH_HDR;
      skip_q  <= 1'b1;
      pkt_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      pkt_v_q <= pkt_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    xb_q  <= xb_d;
    if (pkt_load) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_valid_o = pkt_v_q;
  assign pkt_o       = pkt_q;

  `PS2MCT_ASSERT_IMPL(a_pkt_only_from_y, pkt_load, (phase_q == ps2mct_pkg::PH_Y) && !skip_q)
  `PS2MCT_ASSERT_NEXT(a_bad_hdr_waits, byte_take && !skip_q && (phase_q == ps2mct_pkg::PH_HDR) && !byte_i[ps2mct_pkg::HDR_SYNC], phase_q == ps2mct_pkg::PH_HDR)
  `PS2MCT_ASSERT_NEXT(a_pkt_holds, pkt_v_q && !pkt_ready_i, pkt_v_q && $stable(pkt_q))

endmodule

/* sv/ps2mct_axis.sv */
// One cursor axis: add a delta and clamp to 0..size-1.
`timescale 1ns / 1ps
module ps2mct_axis #(
  parameter int PositionBits = ps2mct_pkg::POSITION_BITS
) (
  input  logic [PositionBits-1:0]                  pos_i,
  input  logic signed [ps2mct_pkg::DELTA_W-1:0]    delta_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]             size_i,
  output logic [PositionBits-1:0]                  pos_o,
  output logic [PositionBits-1:0]                  lim_o
);

  localparam int CalcW = PositionBits + ps2mct_pkg::CFG_W;
  localparam logic [CalcW-1:0] SizeMax = CalcW'(1) << PositionBits;

  logic [CalcW-1:0]        size_ext;
  logic [CalcW-1:0]        size_eff;
  logic [PositionBits-1:0] lim;
  logic signed [CalcW-1:0] sum;

  always_comb begin
    size_ext = CalcW'(size_i);
    // zero acts as one, oversize pins to the full position range
    if (size_ext == '0) begin
      size_eff = CalcW'(1);
    end else if (size_ext > SizeMax) begin
      size_eff = SizeMax;
    end else begin
      size_eff = size_ext;
    end
    lim = PositionBits'(size_eff - CalcW'(1));
    sum = signed'(CalcW'(pos_i))
        + signed'({{(CalcW-ps2mct_pkg::DELTA_W){delta_i[ps2mct_pkg::DELTA_W-1]}}, delta_i});
    if (sum < 0) begin
      pos_o = '0;
    end else if (sum > signed'(CalcW'(lim))) begin
      pos_o = lim;
    end else begin
      pos_o = PositionBits'(sum);
    end
  end

  assign lim_o = lim;

endmodule

/* sv/ps2mct_cursor.sv */
// Cursor update stage: decode deltas, clamp both axes, hold the result beat.
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_macros.svh"
module ps2mct_cursor #(
  parameter int PositionBits = ps2mct_pkg::POSITION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pkt_valid_i,
  output logic                         pkt_ready_o,
  input  ps2mct_pkg::pkt_t             pkt_i,
  input  logic [ps2mct_pkg::CFG_W-1:0] screen_w_i,
  input  logic [ps2mct_pkg::CFG_W-1:0] screen_h_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [PositionBits-1:0]      cursor_x_o,
  output logic [PositionBits-1:0]      cursor_y_o,
  output logic                         left_button_o,
  output logic                         right_button_o,
  output logic                         middle_button_o
);

  logic signed [ps2mct_pkg::DELTA_W-1:0] dx;
  logic signed [ps2mct_pkg::DELTA_W-1:0] dy;
  logic signed [ps2mct_pkg::DELTA_W-1:0] ndy;
  logic [PositionBits-1:0] nx, ny, lim_x, lim_y;
  logic [PositionBits-1:0] pos_x_q, pos_y_q;
  logic [2:0]              btn_q;
  logic                    out_v_q;
  logic                    out_load;

  assign pkt_ready_o = !out_v_q || res_ready_i;
  assign out_load    = pkt_valid_i && pkt_ready_o;

  always_comb begin
    dx  = ps2mct_pkg::signed_delta(pkt_i.x_byte, pkt_i.header[ps2mct_pkg::HDR_X_SIGN],
                                   pkt_i.header[ps2mct_pkg::HDR_X_OVF]);
    dy  = ps2mct_pkg::signed_delta(pkt_i.y_byte, pkt_i.header[ps2mct_pkg::HDR_Y_SIGN],
                                   pkt_i.header[ps2mct_pkg::HDR_Y_OVF]);
    // screen y grows downward
    ndy = -dy;
  end

  ps2mct_axis #(.PositionBits(PositionBits)) u_axis_x (
    .pos_i   (pos_x_q),
    .delta_i (dx),
    .size_i  (screen_w_i),
    .pos_o   (nx),
    .lim_o   (lim_x)
  );

  ps2mct_axis #(.PositionBits(PositionBits)) u_axis_y (
    .pos_i   (pos_y_q),
    .delta_i (ndy),
    .size_i  (screen_h_i),
    .pos_o   (ny),
    .lim_o   (lim_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
        pos_x_q <= nx;
        pos_y_q <= ny;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      btn_q <= {pkt_i.header[ps2mct_pkg::HDR_MIDDLE], pkt_i.header[ps2mct_pkg::HDR_RIGHT],
                pkt_i.header[ps2mct_pkg::HDR_LEFT]};
    end
  end

  assign res_valid_o     = out_v_q;
  assign cursor_x_o      = pos_x_q;
  assign cursor_y_o      = pos_y_q;
  assign left_button_o   = btn_q[0];
  assign right_button_o  = btn_q[1];
  assign middle_button_o = btn_q[2];

  `PS2MCT_ASSERT_NEXT(a_pos_in_range, out_load, (pos_x_q <= $past(lim_x)) && (pos_y_q <= $past(lim_y)))
  `PS2MCT_ASSERT_NEXT(a_pos_held_on_stall, out_v_q && !res_ready_i, $stable(pos_x_q) && $stable(pos_y_q))
  `PS2MCT_ASSERT_NEXT(a_btn_loaded, out_load, out_v_q && (btn_q == $past(pkt_i.header[2:0])))

endmodule

/* sv/ps2_mouse_cursor_tracker.sv */
// Top level of the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
// Usage:
// - pkt channel (pkt_valid_i / pkt_ready_o / pkt_byte_i): one raw mouse byte per beat.
//   The first byte after reset is dropped; then bytes are grouped into
//   header / X / Y packets, a header counting only when its bit 3 is set.
// - res channel (res_valid_o / res_ready_i): one beat per finished packet with the
//   clamped cursor position (y downward) and the three button bits.
// - cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): index 0 is the
//   screen width, index 1 the screen height; other indexes are ignored. Always ready.
//   Write it only while no packet is in flight.
// Timing: a taken Y byte reaches the result beat through the packet register,
//   then the result register. One byte per cycle sustained while res_ready_i is
//   high, set by the single add-and-clamp per axis.
// Reset: cursor at 0,0, screen 1024 x 768, packet sync lost, first byte skipped.
// Stall: while res_ready_i is low the result beat holds; one more packet may wait
//   in the packet register, after which pkt_ready_o drops.
module ps2_mouse_cursor_tracker #(
  parameter int PositionBits = ps2mct_pkg::POSITION_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pkt_valid_i,
  output logic                             pkt_ready_o,
  input  logic [7:0]                       pkt_byte_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [PositionBits-1:0]          cursor_x_o,
  output logic [PositionBits-1:0]          cursor_y_o,
  output logic                             left_button_o,
  output logic                             right_button_o,
  output logic                             middle_button_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [ps2mct_pkg::CFG_W-1:0] screen_w_q, screen_h_q;
  logic                         pkt_v;
  logic                         pkt_rdy;
  ps2mct_pkg::pkt_t             pkt;

  // Config registers: no backpressure, written the cycle the beat lands.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= ps2mct_pkg::WIDTH_RST;
      screen_h_q <= ps2mct_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ps2mct_pkg::REG_SCREEN_WIDTH:  screen_w_q <= cfg_data_i;
        ps2mct_pkg::REG_SCREEN_HEIGHT: screen_h_q <= cfg_data_i;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // Byte stream to packets
  ps2mct_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (pkt_valid_i),
    .byte_ready_o (pkt_ready_o),
    .byte_i       (pkt_byte_i),
    .pkt_valid_o  (pkt_v),
    .pkt_ready_i  (pkt_rdy),
    .pkt_o        (pkt)
  );

  // Packets to cursor position and result beat
  ps2mct_cursor #(.PositionBits(PositionBits)) u_cursor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pkt_valid_i     (pkt_v),
    .pkt_ready_o     (pkt_rdy),
    .pkt_i           (pkt),
    .screen_w_i      (screen_w_q),
    .screen_h_i      (screen_h_q),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o)
  );

endmodule
